// File: rtl/core/sxc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sxc_pkg: shared types and constants of the shuffled-table XOR cipher
// Holds the sequencer states, the control bundles and the stride prime ROM.
// ----------------------------------------------------------------------------
package sxc_pkg;

    localparam logic [31:0] SEED_MUL = 32'h6C07_8965;
    localparam logic [31:0] DFLT_W0  = 32'h6C07_8966;
    localparam logic [31:0] DFLT_W1  = 32'hDD52_54A5;
    localparam logic [31:0] DFLT_W2  = 32'hB952_3B81;
    localparam logic [31:0] DFLT_W3  = 32'h03DF_95B3;

    localparam logic [15:0] ROUNDS_RESET = 16'd1024;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED,
        ST_DRAW,
        ST_RD_LH,
        ST_RD_PQ,
        ST_WR_P,
        ST_WR_Q,
        ST_B_RD_ST,
        ST_B_STRIDE,
        ST_B_MUL,
        ST_B_RD,
        ST_B_OUT
    } sxc_state_t;

    // Controls of the permutation table.
    typedef struct packed {
        logic       clear;
        logic       re;
        logic [7:0] ra;
        logic [7:0] rb;
        logic       we;
        logic [7:0] wa;
        logic [7:0] wd;
    } tbl_ctl_t;

    // Controls of the xorshift word bank.
    typedef struct packed {
        logic        load_dflt;
        logic        step;
        logic        load_en;
        logic [1:0]  load_idx;
        logic [31:0] load_word;
    } rng_ctl_t;

    // Odd primes used as the per-block stride.
    localparam logic [10:0] PRIME_ROM [256] = '{
        11'd3,    11'd5,    11'd7,    11'd11,   11'd13,   11'd17,   11'd19,   11'd23,
        11'd29,   11'd31,   11'd37,   11'd41,   11'd43,   11'd47,   11'd53,   11'd59,
        11'd61,   11'd67,   11'd71,   11'd73,   11'd79,   11'd83,   11'd89,   11'd97,
        11'd101,  11'd103,  11'd107,  11'd109,  11'd113,  11'd127,  11'd131,  11'd137,
        11'd139,  11'd149,  11'd151,  11'd157,  11'd163,  11'd167,  11'd173,  11'd179,
        11'd181,  11'd191,  11'd193,  11'd197,  11'd199,  11'd211,  11'd223,  11'd227,
        11'd229,  11'd233,  11'd239,  11'd241,  11'd251,  11'd257,  11'd263,  11'd269,
        11'd271,  11'd277,  11'd281,  11'd283,  11'd293,  11'd307,  11'd311,  11'd313,
        11'd317,  11'd331,  11'd337,  11'd347,  11'd349,  11'd353,  11'd359,  11'd367,
        11'd373,  11'd379,  11'd383,  11'd389,  11'd397,  11'd401,  11'd409,  11'd419,
        11'd421,  11'd431,  11'd433,  11'd439,  11'd443,  11'd449,  11'd457,  11'd461,
        11'd463,  11'd467,  11'd479,  11'd487,  11'd491,  11'd499,  11'd503,  11'd509,
        11'd521,  11'd523,  11'd541,  11'd547,  11'd557,  11'd563,  11'd569,  11'd571,
        11'd577,  11'd587,  11'd593,  11'd599,  11'd601,  11'd607,  11'd613,  11'd617,
        11'd619,  11'd631,  11'd641,  11'd643,  11'd647,  11'd653,  11'd659,  11'd661,
        11'd673,  11'd677,  11'd683,  11'd691,  11'd701,  11'd709,  11'd719,  11'd727,
        11'd733,  11'd739,  11'd743,  11'd751,  11'd757,  11'd761,  11'd769,  11'd773,
        11'd787,  11'd797,  11'd809,  11'd811,  11'd821,  11'd823,  11'd827,  11'd829,
        11'd839,  11'd853,  11'd857,  11'd859,  11'd863,  11'd877,  11'd881,  11'd883,
        11'd887,  11'd907,  11'd911,  11'd919,  11'd929,  11'd937,  11'd941,  11'd947,
        11'd953,  11'd967,  11'd971,  11'd977,  11'd983,  11'd991,  11'd997,  11'd1009,
        11'd1013, 11'd1019, 11'd1021, 11'd1031, 11'd1033, 11'd1039, 11'd1049, 11'd1051,
        11'd1061, 11'd1063, 11'd1069, 11'd1087, 11'd1091, 11'd1093, 11'd1097, 11'd1103,
        11'd1109, 11'd1117, 11'd1123, 11'd1129, 11'd1151, 11'd1153, 11'd1163, 11'd1171,
        11'd1181, 11'd1187, 11'd1193, 11'd1201, 11'd1213, 11'd1217, 11'd1223, 11'd1229,
        11'd1231, 11'd1237, 11'd1249, 11'd1259, 11'd1277, 11'd1279, 11'd1283, 11'd1289,
        11'd1291, 11'd1297, 11'd1301, 11'd1303, 11'd1307, 11'd1319, 11'd1321, 11'd1327,
        11'd1361, 11'd1367, 11'd1373, 11'd1381, 11'd1399, 11'd1409, 11'd1423, 11'd1427,
        11'd1429, 11'd1433, 11'd1439, 11'd1447, 11'd1451, 11'd1453, 11'd1459, 11'd1471,
        11'd1481, 11'd1483, 11'd1487, 11'd1489, 11'd1493, 11'd1499, 11'd1511, 11'd1523,
        11'd1531, 11'd1543, 11'd1549, 11'd1553, 11'd1559, 11'd1567, 11'd1571, 11'd1579,
        11'd1583, 11'd1597, 11'd1601, 11'd1607, 11'd1609, 11'd1613, 11'd1619, 11'd1621
    };

endpackage
`default_nettype wire

// File: rtl/core/sxc_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sxc_if: request and response channels of the cipher
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface sxc_req_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [31:0] seed;
    logic [7:0]  data_byte;

    modport source (output valid, output func, output seed, output data_byte, input ready);
    modport sink   (input valid, input func, input seed, input data_byte, output ready);
endinterface

interface sxc_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;

    modport source (output valid, output out_byte, input ready);
    modport sink   (input valid, input out_byte, output ready);
endinterface
`default_nettype wire

// File: rtl/core/sxc_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sxc_mul: shared multiply-add unit
// Computes the low 32 bits of a * b + c into a result register.
// ----------------------------------------------------------------------------
module sxc_mul (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    input  wire logic [31:0] c,
    output logic      [31:0] q
);

    logic [31:0] q_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= a * b + c;
        end
    end

    assign q = q_reg;

endmodule
`default_nettype wire

// File: rtl/core/sxc_rng.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sxc_rng: xorshift128 word bank
// Holds the four generator words and steps them one draw per cycle on step.
// ----------------------------------------------------------------------------
module sxc_rng (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire sxc_pkg::rng_ctl_t ctl,
    output logic      [15:0]     draw_low
);
    import sxc_pkg::*;

    logic [31:0] w_reg [4];
    logic [31:0] a_s1;
    logic [31:0] a_s2;
    logic [31:0] b_s1;
    logic [31:0] w3_next;

    always_comb
    begin
        a_s1    = w_reg[0] ^ (w_reg[0] << 11);
        a_s2    = a_s1 ^ (a_s1 >> 8);
        b_s1    = w_reg[3] ^ (w_reg[3] >> 19);
        w3_next = a_s2 ^ b_s1;
    end

    assign draw_low = w3_next[15:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg[0] <= DFLT_W0;
            w_reg[1] <= DFLT_W1;
            w_reg[2] <= DFLT_W2;
            w_reg[3] <= DFLT_W3;
        end
        else
        begin
            priority if (ctl.load_dflt)
            begin
                w_reg[0] <= DFLT_W0;
                w_reg[1] <= DFLT_W1;
                w_reg[2] <= DFLT_W2;
                w_reg[3] <= DFLT_W3;
            end
            else if (ctl.load_en)
            begin
                w_reg[ctl.load_idx] <= ctl.load_word;
            end
            else if (ctl.step)
            begin
                w_reg[0] <= w_reg[1];
                w_reg[1] <= w_reg[2];
                w_reg[2] <= w_reg[3];
                w_reg[3] <= w3_next;
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/sxc_tbl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sxc_tbl: 256-entry permutation table
// Two registered read ports and one write port. An entry not written since
// the last clear reads as its own index, which gives the identity table.
// ----------------------------------------------------------------------------
module sxc_tbl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire sxc_pkg::tbl_ctl_t ctl,
    output logic      [7:0]      rd_a,
    output logic      [7:0]      rd_b
);
    import sxc_pkg::*;

    logic [7:0]   mem [256];
    logic [255:0] vld_reg;
    logic [7:0]   rd_a_reg;
    logic [7:0]   rd_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ctl.clear)
        begin
            vld_reg <= '0;
        end
        else if (ctl.we)
        begin
            vld_reg[ctl.wa] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[ctl.wa] <= ctl.wd;
        end
        if (ctl.re)
        begin
            rd_a_reg <= vld_reg[ctl.ra] ? mem[ctl.ra] : ctl.ra;
            rd_b_reg <= vld_reg[ctl.rb] ? mem[ctl.rb] : ctl.rb;
        end
    end

    assign rd_a = rd_a_reg;
    assign rd_b = rd_b_reg;

endmodule
`default_nettype wire

// File: rtl/core/shuffled_table_stride_xor_cipher_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// shuffled_table_stride_xor_cipher_top: shuffled-table stride XOR cipher
// Keys a 256-entry permutation from a seed and XORs data bytes with it.
// ----------------------------------------------------------------------------
// A request item with func = 0 keys the block: the table returns to the
// identity at once, three generator words are chained from a nonzero seed
// through the shared multiplier (skipped for a zero seed), and the table is
// shuffled for shuffle_rounds rounds. A round walks draw, read both bytes,
// read both indirect entries and two writes, or only the first two steps
// when the drawn bytes are equal, as the single-write table takes one swap
// half per cycle. A key item gives no response. An item with func = 1
// ciphers one byte: its index is formed by the shared multiplier and then
// read from the table, so each byte walks multiplier, table read and output
// register in turn, and the next item is taken once that register is
// loaded. At each 256-byte boundary the stride is first reloaded from the
// prime ROM through an extra table read. The response sits in an output
// register, and a new request is taken while it waits; a byte whose result
// finds that register still full waits in its last state. shuffle_rounds is
// written through cfg_we/cfg_wdata, by the user only while the block is idle,
// which the block does not enforce. After reset the table is the identity and
// the position is zero, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module shuffled_table_stride_xor_cipher_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    sxc_req_if.sink          req,
    sxc_rsp_if.source        rsp,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata
);
    import sxc_pkg::*;

    sxc_state_t  state_reg;
    sxc_state_t  state_next;

    logic [15:0] shuffle_rounds_reg;
    logic [15:0] rounds_left_reg;
    logic [1:0]  seed_idx_reg;
    logic [31:0] seed_reg;
    logic [15:0] pos_reg;
    logic [7:0]  stride_reg;
    logic [7:0]  data_reg;
    logic [15:0] lohi_reg;
    logic [7:0]  p_reg;
    logic [7:0]  q_reg;
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;

    tbl_ctl_t    tbl_ctl;
    rng_ctl_t    rng_ctl;
    logic [7:0]  tbl_rd_a;
    logic [7:0]  tbl_rd_b;
    logic [15:0] draw_low;

    logic        mul_en;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [31:0] mul_c;
    logic [31:0] mul_q;
    logic [31:0] chain_prev;

    logic        req_fire;
    logic        out_load;
    logic        draw_same;

    assign req_fire  = req.valid && req.ready;
    assign draw_same = (lohi_reg[7:0] == lohi_reg[15:8]);

    sxc_tbl u_tbl (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (tbl_ctl),
        .rd_a  (tbl_rd_a),
        .rd_b  (tbl_rd_b)
    );

    sxc_rng u_rng (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (rng_ctl),
        .draw_low (draw_low)
    );

    sxc_mul u_mul (
        .clk (clk),
        .en  (mul_en),
        .a   (mul_a),
        .b   (mul_b),
        .c   (mul_c),
        .q   (mul_q)
    );

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    if (req.func)
                    begin
                        state_next = (pos_reg[7:0] == 8'd0) ? ST_B_RD_ST : ST_B_MUL;
                    end
                    else if (req.seed != 32'd0)
                    begin
                        state_next = ST_SEED;
                    end
                    else
                    begin
                        state_next = (shuffle_rounds_reg == 16'd0) ? ST_IDLE : ST_DRAW;
                    end
                end
            end
            ST_SEED:
            begin
                if (seed_idx_reg == 2'd3)
                begin
                    state_next = (rounds_left_reg == 16'd0) ? ST_IDLE : ST_DRAW;
                end
            end
            ST_DRAW:     state_next = ST_RD_LH;
            ST_RD_LH:
            begin
                if (!draw_same)
                begin
                    state_next = ST_RD_PQ;
                end
                else
                begin
                    state_next = (rounds_left_reg == 16'd0) ? ST_IDLE : ST_DRAW;
                end
            end
            ST_RD_PQ:    state_next = ST_WR_P;
            ST_WR_P:     state_next = ST_WR_Q;
            ST_WR_Q:     state_next = (rounds_left_reg == 16'd0) ? ST_IDLE : ST_DRAW;
            ST_B_RD_ST:  state_next = ST_B_STRIDE;
            ST_B_STRIDE: state_next = ST_B_MUL;
            ST_B_MUL:    state_next = ST_B_RD;
            ST_B_RD:     state_next = ST_B_OUT;
            ST_B_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Output logic: drives the table, the generator, the multiplier and req.ready.
    always_comb
    begin
        tbl_ctl    = '0;
        rng_ctl    = '0;
        mul_en     = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        mul_c      = '0;
        req.ready  = 1'b0;
        out_load   = 1'b0;
        chain_prev = (seed_idx_reg == 2'd0) ? seed_reg : mul_q;
        unique case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req_fire && !req.func)
                begin
                    tbl_ctl.clear     = 1'b1;
                    rng_ctl.load_dflt = 1'b1;
                end
            end
            ST_SEED:
            begin
                // The word finished in the previous cycle is stored while the
                // next one is started from it.
                if (seed_idx_reg != 2'd0)
                begin
                    rng_ctl.load_en   = 1'b1;
                    rng_ctl.load_idx  = seed_idx_reg - 2'd1;
                    rng_ctl.load_word = mul_q;
                end
                if (seed_idx_reg != 2'd3)
                begin
                    mul_en = 1'b1;
                    mul_a  = SEED_MUL;
                    mul_b  = chain_prev ^ (chain_prev >> 30);
                    mul_c  = {30'd0, seed_idx_reg} + 32'd1;
                end
            end
            ST_DRAW:
            begin
                rng_ctl.step = 1'b1;
            end
            ST_RD_LH:
            begin
                if (!draw_same)
                begin
                    tbl_ctl.re = 1'b1;
                    tbl_ctl.ra = lohi_reg[7:0];
                    tbl_ctl.rb = lohi_reg[15:8];
                end
            end
            ST_RD_PQ:
            begin
                tbl_ctl.re = 1'b1;
                tbl_ctl.ra = tbl_rd_a;
                tbl_ctl.rb = tbl_rd_b;
            end
            ST_WR_P:
            begin
                tbl_ctl.we = 1'b1;
                tbl_ctl.wa = p_reg;
                tbl_ctl.wd = tbl_rd_b;
            end
            ST_WR_Q:
            begin
                tbl_ctl.we = 1'b1;
                tbl_ctl.wa = q_reg;
                tbl_ctl.wd = tbl_rd_a;
            end
            ST_B_RD_ST:
            begin
                tbl_ctl.re = 1'b1;
                tbl_ctl.ra = pos_reg[15:8];
                tbl_ctl.rb = pos_reg[15:8];
            end
            ST_B_STRIDE:
            begin
                tbl_ctl.re = 1'b0;
            end
            ST_B_MUL:
            begin
                // Only the low byte of the product is used, so the low byte
                // of position plus one and of the stride suffices.
                mul_en = 1'b1;
                mul_a  = {24'd0, pos_reg[7:0] + 8'd1};
                mul_b  = {24'd0, stride_reg};
            end
            ST_B_RD:
            begin
                tbl_ctl.re = 1'b1;
                tbl_ctl.ra = mul_q[7:0];
                tbl_ctl.rb = mul_q[7:0];
            end
            ST_B_OUT:
            begin
                out_load = !out_valid_reg || rsp.ready;
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            shuffle_rounds_reg <= ROUNDS_RESET;
            rounds_left_reg    <= '0;
            seed_idx_reg       <= '0;
            pos_reg            <= '0;
            stride_reg         <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                shuffle_rounds_reg <= cfg_wdata;
            end
            if (req_fire && !req.func)
            begin
                rounds_left_reg <= shuffle_rounds_reg;
                seed_idx_reg    <= '0;
                pos_reg         <= '0;
            end
            if (state_reg == ST_SEED)
            begin
                seed_idx_reg <= seed_idx_reg + 2'd1;
            end
            if (state_reg == ST_DRAW)
            begin
                rounds_left_reg <= rounds_left_reg - 16'd1;
            end
            if (state_reg == ST_B_STRIDE)
            begin
                stride_reg <= PRIME_ROM[tbl_rd_a][7:0];
            end
            if (out_load)
            begin
                pos_reg       <= pos_reg + 16'd1;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            seed_reg <= req.seed;
            data_reg <= req.data_byte;
        end
        if (state_reg == ST_DRAW)
        begin
            lohi_reg <= draw_low;
        end
        if (state_reg == ST_RD_PQ)
        begin
            p_reg <= tbl_rd_a;
            q_reg <= tbl_rd_b;
        end
        if (out_load)
        begin
            out_byte_reg <= data_reg ^ tbl_rd_a;
        end
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.out_byte = out_byte_reg;

endmodule
`default_nettype wire

// File: rtl/core/sxc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sxc_checker: port-level checks of the cipher
// Watches the request and response channels of the top level over time.
// ----------------------------------------------------------------------------
module sxc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        req_valid,
    input wire logic        req_ready,
    input wire logic        req_func,
    input wire logic [31:0] req_seed,
    input wire logic        rsp_valid,
    input wire logic        rsp_ready,
    input wire logic [7:0]  rsp_out_byte
);

    // The handshake controls of the block are never unknown out of reset.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown(req_ready) && !$isunknown(rsp_valid))
        else $error("unknown handshake control");

    // A byte item passes the multiplier, a table read and the output stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_func |=> !req_ready ##1 !req_ready ##1 !req_ready)
        else $error("byte item finished too early");

    // A seeded key holds off new requests while its words pass the multiplier.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && !req_func && req_seed != 32'd0
        |=> !req_ready ##1 !req_ready ##1 !req_ready ##1 !req_ready)
        else $error("seeded key finished too early");

    // A stalled response holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte))
        else $error("stalled response changed");

endmodule

bind shuffled_table_stride_xor_cipher_top sxc_checker u_sxc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .req_func     (req.func),
    .req_seed     (req.seed),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_out_byte (rsp.out_byte)
);
`default_nettype wire

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the shuffled-table stride XOR cipher
// Streams key and byte items through the request channel under random
// back-pressure and compares every response with a cycle-free software model.
// ----------------------------------------------------------------------------
module tb;
    import sxc_pkg::*;

    // Item kinds on the request channel.
    localparam logic FUNC_KEY  = 1'b0;
    localparam logic FUNC_BYTE = 1'b1;

    // The slowest legal run is dominated by the one key at 65535 rounds, with
    // the other keys and bytes adding to it. The limit leaves a wide margin
    // above that.
    localparam int CYCLE_LIMIT   = 4_000_000;
    localparam int SETTLE_CYCLES = 16;
    localparam int IDLE_PERCENT  = 11;

    localparam logic [31:0] MIX_MUL  = 32'h6C07_8965;
    localparam logic [31:0] INIT_W0  = 32'h6C07_8966;
    localparam logic [31:0] INIT_W1  = 32'hDD52_54A5;
    localparam logic [31:0] INIT_W2  = 32'hB952_3B81;
    localparam logic [31:0] INIT_W3  = 32'h03DF_95B3;

    typedef struct {
        logic        func;
        logic [31:0] seed;
        logic [7:0]  data_byte;
        bit          drain_first;   // hold this item back until all results are in
    } cipher_req_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    sxc_req_if req_ch();
    sxc_rsp_if rsp_ch();

    shuffled_table_stride_xor_cipher_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Cipher model. It holds its own copy of the permutation, the xorshift
    // words, the stream position and the current stride, and is advanced once
    // per accepted request item.
    // ------------------------------------------------------------------------
    logic [7:0]  perm_model [256];
    logic [31:0] xs_state [4];
    logic [15:0] stream_pos;
    logic [10:0] stride_now;
    logic [15:0] rounds_now;
    logic [10:0] stride_primes [256];

    // Bench bookkeeping.
    cipher_req_t pending_items [$];
    logic [7:0]  expected_bytes [$];
    cipher_req_t in_flight;
    logic [7:0]  want_byte;
    int          items_sent = 0;
    int          items_taken = 0;
    int          keys_taken = 0;
    int          results_seen = 0;
    int          mismatches = 0;
    int          settings_used = 0;
    int          cycle_count = 0;
    int          idle_pct = IDLE_PERCENT;

    function automatic logic [31:0] chain_word(input logic [31:0] prev, input logic [31:0] add);
        return MIX_MUL * (prev ^ (prev >> 30)) + add;
    endfunction

    function automatic void load_identity();
        int k;
        for (k = 0; k < 256; k++)
            perm_model[k] = 8'(k);
    endfunction

    function automatic void load_init_words();
        xs_state[0] = INIT_W0;
        xs_state[1] = INIT_W1;
        xs_state[2] = INIT_W2;
        xs_state[3] = INIT_W3;
    endfunction

    // Keying: rebuild the identity, reseed the generator and shuffle the
    // table with indirect swaps, one per round whose two drawn bytes differ.
    function automatic void apply_key(input logic [31:0] seed);
        logic [31:0] a;
        logic [31:0] b;
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [7:0]  p;
        logic [7:0]  q;
        logic [7:0]  t;
        int          r;
        load_identity();
        load_init_words();
        if (seed != 32'd0)
        begin
            xs_state[0] = chain_word(seed, 32'd1);
            xs_state[1] = chain_word(xs_state[0], 32'd2);
            xs_state[2] = chain_word(xs_state[1], 32'd3);
        end
        for (r = 0; r < int'(rounds_now); r++)
        begin
            a = xs_state[0];
            b = xs_state[3];
            xs_state[0] = xs_state[1];
            xs_state[1] = xs_state[2];
            xs_state[2] = b;
            a = a ^ (a << 11);
            a = a ^ (a >> 8);
            b = b ^ (b >> 19);
            xs_state[3] = a ^ b;
            lo = xs_state[3][7:0];
            hi = xs_state[3][15:8];
            if (lo != hi)
            begin
                p = perm_model[lo];
                q = perm_model[hi];
                t = perm_model[p];
                perm_model[p] = perm_model[q];
                perm_model[q] = t;
            end
        end
        stream_pos = 16'd0;
    endfunction

    // One data byte: the stride is reloaded at each 256-byte block, then the
    // pad is the table entry at (pos + 1) * stride, taken modulo 256.
    function automatic logic [7:0] cipher_byte(input logic [7:0] d);
        logic [31:0] prod;
        logic [7:0]  pad;
        if (stream_pos[7:0] == 8'd0)
            stride_now = stride_primes[perm_model[stream_pos[15:8]]];
        prod = (32'(stream_pos) + 32'd1) * 32'(stride_now);
        pad = perm_model[prod[7:0]];
        stream_pos = stream_pos + 16'd1;
        return d ^ pad;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("cycle %0d: mismatch: %s", cycle_count, what);
    endtask

    // ------------------------------------------------------------------------
    // Request driver. An item stays on the channel until it is taken; at the
    // taking edge the model is advanced, and the next item (if any, if the random
    // idle draw allows, and for a held item if no result is due) is put up then.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid     <= 1'b0;
            req_ch.func      <= FUNC_KEY;
            req_ch.seed      <= 32'd0;
            req_ch.data_byte <= 8'd0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                if (in_flight.func == FUNC_KEY)
                begin
                    apply_key(in_flight.seed);
                    keys_taken++;
                end
                else
                begin
                    expected_bytes.push_back(cipher_byte(in_flight.data_byte));
                end
                items_taken++;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct &&
                    (!pending_items[0].drain_first || expected_bytes.size() == 0))
                begin
                    in_flight = pending_items.pop_front();
                    items_sent++;
                    req_ch.valid     <= 1'b1;
                    req_ch.func      <= in_flight.func;
                    req_ch.seed      <= in_flight.seed;
                    req_ch.data_byte <= in_flight.data_byte;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Response monitor. Each taken response is matched against the oldest
    // predicted byte; ready is redrawn every cycle.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                results_seen++;
                if (expected_bytes.size() == 0)
                begin
                    report_mismatch($sformatf("out_byte %02h with no item outstanding",
                                              rsp_ch.out_byte));
                end
                else
                begin
                    want_byte = expected_bytes.pop_front();
                    if (rsp_ch.out_byte !== want_byte)
                        report_mismatch($sformatf("out_byte %02h, model gives %02h",
                                                  rsp_ch.out_byte, want_byte));
                end
            end
            rsp_ch.ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still outstanding",
                     cycle_count, expected_bytes.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    function automatic void queue_key(input logic [31:0] seed, input bit hold);
        cipher_req_t it;
        it.func        = FUNC_KEY;
        it.seed        = seed;
        it.data_byte   = 8'($urandom);
        it.drain_first = hold;
        pending_items.push_back(it);
    endfunction

    function automatic void queue_byte(input logic [7:0] d, input bit hold);
        cipher_req_t it;
        it.func        = FUNC_BYTE;
        it.seed        = $urandom;
        it.data_byte   = d;
        it.drain_first = hold;
        pending_items.push_back(it);
    endfunction

    function automatic logic [31:0] pick_seed();
        return ($urandom_range(9) == 0) ? 32'd0 : 32'($urandom);
    endfunction

    // Waits until every queued item was taken and every predicted byte came
    // back. Each phase ends with a byte item, so its response also marks the
    // end of any key before it; the settle time covers the output register.
    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_items.size() != 0 || items_sent != items_taken ||
               expected_bytes.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_rounds(input logic [15:0] value);
        wait_drained();
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        rounds_now = value;
        settings_used++;
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        int n;
        int k;
        int found;
        int sess;
        int nkeys;
        int kk;
        int nb;
        int b;
        bit is_prime;

        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = 16'd0;
        req_ch.valid     = 1'b0;
        req_ch.func      = FUNC_KEY;
        req_ch.seed      = 32'd0;
        req_ch.data_byte = 8'd0;
        rsp_ch.ready     = 1'b0;

        // The stride ROM holds the first 256 odd primes.
        found = 0;
        n = 3;
        while (found < 256)
        begin
            is_prime = 1'b1;
            for (k = 3; k * k <= n; k += 2)
                if (n % k == 0)
                    is_prime = 1'b0;
            if (is_prime)
            begin
                stride_primes[found] = 11'(n);
                found++;
            end
            n += 2;
        end

        // Model state after reset.
        rounds_now = ROUNDS_RESET;
        load_identity();
        load_init_words();
        stream_pos = 16'd0;
        stride_now = 11'd0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Bytes before any key run on the identity table from position zero.
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h5A, 1'b0);
        // A zero seed keeps the default generator words; keying at the reset
        // round count also checks that count.
        queue_key(32'h0000_0000, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        // Two keys back to back; only the second one must count.
        queue_key(32'hFFFF_FFFF, 1'b0);
        queue_key(32'h0000_0001, 1'b0);
        queue_byte(8'hA5, 1'b1);
        queue_byte(8'h3C, 1'b0);
        queue_key(32'h8000_0000, 1'b0);
        queue_byte(8'h81, 1'b0);

        // No rounds at all: the table stays the identity after the key.
        write_rounds(16'd0);
        queue_key(pick_seed(), 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h7E, 1'b0);

        // The largest round count, once, since its key runs the longest.
        write_rounds(16'hFFFF);
        queue_key(32'($urandom), 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);

        // A single round.
        write_rounds(16'd1);
        queue_key(32'($urandom), 1'b0);
        queue_byte(8'hC3, 1'b0);
        queue_byte(8'h18, 1'b0);

        // Random sessions: a round setting, then a few keys, each followed by
        // a burst of bytes. Session 1 is one long stream with no idling on
        // either side, long enough to cross the first 256-byte block.
        for (sess = 0; sess < 5; sess++)
        begin
            case (sess)
                0: write_rounds(16'($urandom_range(2, 255)));
                1: write_rounds(ROUNDS_RESET);
                2: write_rounds(16'($urandom_range(256, 2000)));
                3: write_rounds(16'($urandom_range(0, 15)));
                default: write_rounds(16'($urandom_range(1, 2000)));
            endcase
            if (sess == 1)
            begin
                idle_pct = 0;
                queue_key(pick_seed(), 1'b0);
                for (b = 0; b < 300 + $urandom_range(0, 40); b++)
                    queue_byte(8'($urandom), 1'b0);
            end
            else
            begin
                nkeys = $urandom_range(3, 5);
                for (kk = 0; kk < nkeys; kk++)
                begin
                    // Now and then a key follows a key directly, or is left
                    // out so that the stream carries on under the old key.
                    if ($urandom_range(5) != 0)
                        queue_key(pick_seed(), 1'b0);
                    if ($urandom_range(7) == 0)
                        queue_key(pick_seed(), 1'b0);
                    nb = $urandom_range(1, 40);
                    for (b = 0; b < nb; b++)
                        queue_byte(8'($urandom), ($urandom_range(49) == 0));
                end
                queue_byte(8'($urandom), 1'b0);
            end
            wait_drained();
            idle_pct = IDLE_PERCENT;
        end

        wait_drained();
        $display("Ran %0d keys and %0d cipher bytes over %0d round settings,",
                 keys_taken, results_seen, settings_used);
        $display("0 and 65535 included, with idle and stall gaps on both channels.");
        if (mismatches == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/sxc_pkg.sv
rtl/core/sxc_if.sv
rtl/core/sxc_mul.sv
rtl/core/sxc_rng.sv
rtl/core/sxc_tbl.sv
rtl/core/shuffled_table_stride_xor_cipher_top.sv
rtl/core/sxc_checker.sv
test/tb.sv
